[hw/rtl/hpc_pkg.sv]
// Package for the hysteresis pump controller: payload and state types,
// register map codes and reset values. No dependencies.
`default_nettype none

package hpc_pkg;

    // Field widths fixed by the interface.
    localparam int MoistureWidth = 10;
    localparam int TicksWidth    = 16;
    localparam int AddrWidth     = 4;
    localparam int DataWidth     = 32;

    // Register indexes, taken from paddr[3:2].
    typedef enum logic [1:0] {
        REG_LOW_MOISTURE     = 2'd0,
        REG_HIGH_MOISTURE    = 2'd1,
        REG_AUTO_LIMIT_TICKS = 2'd2,
        REG_MANUAL_TICKS     = 2'd3
    } hpc_reg_idx_t;

    // Reset values of the configuration registers.
    localparam logic [MoistureWidth-1:0] LowMoistureReset    = 10'd300;
    localparam logic [MoistureWidth-1:0] HighMoistureReset   = 10'd700;
    localparam logic [TicksWidth-1:0]    AutoLimitTicksReset = 16'd60;
    localparam logic [TicksWidth-1:0]    ManualTicksReset    = 16'd10;

    localparam logic [TicksWidth-1:0]    TicksMax            = 16'hFFFF;

    // One control tick.
    typedef struct packed {
        logic [MoistureWidth-1:0] moisture;
        logic                     mode_button;
        logic                     water_button;
    } hpc_in_t;

    // One result.
    typedef struct packed {
        logic                  pump_on;
        logic                  manual_mode;
        logic [TicksWidth-1:0] elapsed_ticks;
    } hpc_out_t;

    // Configuration handed from the register block to the tick logic.
    typedef struct packed {
        logic [MoistureWidth-1:0] low_moisture;
        logic [MoistureWidth-1:0] high_moisture;
        logic [TicksWidth-1:0]    auto_limit_ticks;
        logic [TicksWidth-1:0]    manual_ticks;
    } hpc_cfg_t;

    // Controller state carried from tick to tick.
    typedef struct packed {
        logic                  mode_is_manual;
        logic                  pump_running;
        logic [TicksWidth-1:0] run_timer;
    } hpc_state_t;

endpackage

`default_nettype wire

[hw/rtl/hpc_cfg_regs.sv]
// APB-style configuration registers of the pump controller.
// Depends on hpc_pkg for the register map and the configuration struct.
`default_nettype none

module hpc_cfg_regs (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         psel,
    input  wire logic                         penable,
    input  wire logic                         pwrite,
    input  wire logic [hpc_pkg::AddrWidth-1:0] paddr,
    input  wire logic [hpc_pkg::DataWidth-1:0] pwdata,
    output logic      [hpc_pkg::DataWidth-1:0] prdata,
    output logic                              pready,
    output hpc_pkg::hpc_cfg_t                 cfg
);
    import hpc_pkg::*;

    hpc_cfg_t     cfg_reg;
    hpc_reg_idx_t reg_idx;
    logic         wr_en;

    assign reg_idx = hpc_reg_idx_t'(paddr[3:2]);
    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;

    // Register writes on the access cycle of a write transfer.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.low_moisture     <= LowMoistureReset;
            cfg_reg.high_moisture    <= HighMoistureReset;
            cfg_reg.auto_limit_ticks <= AutoLimitTicksReset;
            cfg_reg.manual_ticks     <= ManualTicksReset;
        end
        else if (wr_en)
        begin
            case (reg_idx)
                REG_LOW_MOISTURE:     cfg_reg.low_moisture     <= pwdata[MoistureWidth-1:0];
                REG_HIGH_MOISTURE:    cfg_reg.high_moisture    <= pwdata[MoistureWidth-1:0];
                REG_AUTO_LIMIT_TICKS: cfg_reg.auto_limit_ticks <= pwdata[TicksWidth-1:0];
                REG_MANUAL_TICKS:     cfg_reg.manual_ticks     <= pwdata[TicksWidth-1:0];
                default:              ;
            endcase
        end
    end

    // Read data, zero-extended to the bus width.
    always_comb
    begin
        case (reg_idx)
            REG_LOW_MOISTURE:
                prdata = {{(DataWidth-MoistureWidth){1'b0}}, cfg_reg.low_moisture};
            REG_HIGH_MOISTURE:
                prdata = {{(DataWidth-MoistureWidth){1'b0}}, cfg_reg.high_moisture};
            REG_AUTO_LIMIT_TICKS:
                prdata = {{(DataWidth-TicksWidth){1'b0}}, cfg_reg.auto_limit_ticks};
            REG_MANUAL_TICKS:
                prdata = {{(DataWidth-TicksWidth){1'b0}}, cfg_reg.manual_ticks};
            default:
                prdata = '0;
        endcase
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

[hw/rtl/hpc_step.sv]
// Combinational tick logic: mode toggle, manual start, hysteresis and timeout.
// Depends on hpc_pkg for the item, configuration and state structs.
`default_nettype none

module hpc_step (
    input  wire hpc_pkg::hpc_in_t    item,
    input  wire hpc_pkg::hpc_cfg_t   cfg,
    input  wire hpc_pkg::hpc_state_t state_cur,
    output hpc_pkg::hpc_state_t      state_nxt
);
    import hpc_pkg::*;

    // The steps of one tick, applied in order to a working copy of the state.
    always_comb
    begin
        logic                  mode;
        logic                  pump;
        logic [TicksWidth-1:0] timer;

        mode  = state_cur.mode_is_manual;
        pump  = state_cur.pump_running;
        timer = state_cur.run_timer;

        // Mode toggle; entering manual mode stops any run.
        if (item.mode_button)
        begin
            if (!mode)
            begin
                mode  = 1'b1;
                pump  = 1'b0;
                timer = '0;
            end
            else
            begin
                mode = 1'b0;
            end
        end

        // Manual start only when idle in manual mode.
        if (item.water_button && mode && !pump)
        begin
            pump  = 1'b1;
            timer = '0;
        end

        if (!mode)
        begin
            if (!pump)
            begin
                // Hysteresis start; the timer does not count on this tick.
                if (item.moisture < cfg.low_moisture)
                begin
                    pump  = 1'b1;
                    timer = '0;
                end
            end
            else
            begin
                if (timer != TicksMax)
                    timer = timer + 16'd1;
                if ((item.moisture > cfg.high_moisture) || (timer >= cfg.auto_limit_ticks))
                begin
                    pump  = 1'b0;
                    timer = '0;
                end
            end
        end
        else if (pump)
        begin
            if (timer != TicksMax)
                timer = timer + 16'd1;
            if (timer >= cfg.manual_ticks)
            begin
                pump  = 1'b0;
                timer = '0;
            end
        end

        state_nxt.mode_is_manual = mode;
        state_nxt.pump_running   = pump;
        state_nxt.run_timer      = timer;
    end

endmodule

`default_nettype wire

[hw/rtl/hysteresis_pump_controller.sv]
// Top level of the hysteresis pump controller: input register, tick logic,
// state and result registers. Depends on hpc_pkg, hpc_cfg_regs and hpc_step.
`default_nettype none

// One input transfer is one control tick and yields exactly one result. The
// block takes a new tick every clock cycle while in_stall is low; a tick is
// taken into the input register, and its result is loaded into the result
// register when the item advances. The combinational tick logic sits
// between the input register and the result and state registers. A stall
// on the result side holds the result register and, one item later, the
// input register; stall on the input side rises only while both hold an
// item. Configuration registers are written over the APB-style port and
// should only be changed while no tick is in flight.
module hysteresis_pump_controller (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         in_valid,
    output logic                              in_stall,
    input  wire hpc_pkg::hpc_in_t             in_data,
    output logic                              out_valid,
    input  wire logic                         out_stall,
    output hpc_pkg::hpc_out_t                 out_data,
    input  wire logic                         psel,
    input  wire logic                         penable,
    input  wire logic                         pwrite,
    input  wire logic [hpc_pkg::AddrWidth-1:0] paddr,
    input  wire logic [hpc_pkg::DataWidth-1:0] pwdata,
    output logic      [hpc_pkg::DataWidth-1:0] prdata,
    output logic                              pready
);
    import hpc_pkg::*;

    hpc_cfg_t   cfg;
    hpc_in_t    item_reg;
    logic       item_vld_reg;
    hpc_out_t   res_reg;
    logic       res_vld_reg;
    hpc_state_t state_reg;
    hpc_state_t state_next;
    logic       advance;
    logic       in_take;

    // Configuration registers.
    hpc_cfg_regs u_cfg_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // Tick logic on the registered item and the current state.
    hpc_step u_step (
        .item      (item_reg),
        .cfg       (cfg),
        .state_cur (state_reg),
        .state_nxt (state_next)
    );

    // The held item moves on when the result register is free or draining.
    assign advance  = item_vld_reg && (!res_vld_reg || !out_stall);
    assign in_stall = item_vld_reg && !advance;
    assign in_take  = in_valid && !in_stall;

    // Input register control.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            item_vld_reg <= 1'b0;
        else if (!in_stall)
            item_vld_reg <= in_valid;
    end

    // Input register payload.
    always_ff @(posedge clk)
    begin
        if (in_take)
            item_reg <= in_data;
    end

    // Controller state, updated once per processed tick.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.mode_is_manual <= 1'b0;
            state_reg.pump_running   <= 1'b0;
            state_reg.run_timer      <= '0;
        end
        else if (advance)
        begin
            state_reg <= state_next;
        end
    end

    // Result register control.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            res_vld_reg <= 1'b0;
        else
            res_vld_reg <= advance || (res_vld_reg && out_stall);
    end

    // Result register payload.
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            res_reg.pump_on       <= state_next.pump_running;
            res_reg.manual_mode   <= state_next.mode_is_manual;
            res_reg.elapsed_ticks <= state_next.run_timer;
        end
    end

    assign out_valid = res_vld_reg;
    assign out_data  = res_reg;

endmodule

`default_nettype wire

[hw/rtl/hpc_checker.sv]
// Port-level assertions for the hysteresis pump controller and their bind.
// Depends on hpc_pkg for the result struct.
`default_nettype none

module hpc_checker (
    input wire logic              clk,
    input wire logic              rst_n,
    input wire logic              out_valid,
    input wire logic              out_stall,
    input wire hpc_pkg::hpc_out_t out_data
);
    import hpc_pkg::*;

    // A stalled result transfer holds its valid and its payload.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

    // Every stop clears the timer, so an idle pump always reports zero.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_data.pump_on |-> out_data.elapsed_ticks == '0)
    else $error("pump off with nonzero timer");

    // A running pump is always below its limit, so the timer never saturates.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.pump_on |-> out_data.elapsed_ticks != TicksMax)
    else $error("pump running with saturated timer");

endmodule

bind hysteresis_pump_controller hpc_checker u_hpc_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
);

`default_nettype wire
